// ===== rtl/core/phong_point_shader_assert.svh =====
// Assertion helpers for the shader core. Both use the clk and rst of the
// module that includes this file.
`ifndef PHONG_POINT_SHADER_ASSERT_SVH
`define PHONG_POINT_SHADER_ASSERT_SVH

// Condition must never be true outside reset.
`define PHS_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define PHS_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ===== rtl/core/phs_pkg.sv =====
`timescale 1ns / 1ps
package phs_pkg;

  localparam int Q_W        = 16;     // internal vector format, Q2.14
  localparam int FRAC       = 14;
  localparam int NL14_W     = 18;     // rounded N.L, positive only
  localparam int DL_W       = 16;     // diffuse color times light color
  localparam int VLEN_W     = 17;     // integer square root of V.V
  localparam int COS_W      = 15;     // cosine, 0 .. 1.0
  localparam int ONE_Q      = 16384;
  localparam int SHIN_RESET = 10;
  localparam int WDATA_W    = 24;
  localparam int IDX_W      = 2;
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = 2;
  localparam int CNT_W      = 3;

  // Register indexes
  localparam logic [IDX_W-1:0] REG_DIFFUSE   = 2'd0;
  localparam logic [IDX_W-1:0] REG_SPECULAR  = 2'd1;
  localparam logic [IDX_W-1:0] REG_SHININESS = 2'd2;

  typedef logic signed [Q_W-1:0] q14_t;

  // Work item handed from the front end to the shading pipeline
  typedef struct packed {
    q14_t [2:0]            n;
    q14_t [2:0]            l;
    q14_t [2:0]            v;
    logic [2:0][7:0]       lc;
    logic [NL14_W-1:0]     nl14;
    logic                  lit;
  } front_item_t;

  // Context carried alongside the specular math
  typedef struct packed {
    logic                  lit;
    logic [NL14_W-1:0]     nl14;
    logic [2:0][DL_W-1:0]  dl;
  } ctx_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             full;
    logic             empty;
  } fifo_stat_t;

endpackage

// ===== rtl/core/phs_in_if.sv =====
`timescale 1ns / 1ps
interface phs_in_if #(parameter int VEC_BITS = 16);
  logic                       valid;
  logic                       ready;
  logic signed [VEC_BITS-1:0] normal_x;
  logic signed [VEC_BITS-1:0] normal_y;
  logic signed [VEC_BITS-1:0] normal_z;
  logic signed [VEC_BITS-1:0] light_x;
  logic signed [VEC_BITS-1:0] light_y;
  logic signed [VEC_BITS-1:0] light_z;
  logic signed [VEC_BITS-1:0] view_x;
  logic signed [VEC_BITS-1:0] view_y;
  logic signed [VEC_BITS-1:0] view_z;
  logic [7:0]                 light_red;
  logic [7:0]                 light_green;
  logic [7:0]                 light_blue;

  modport source (output valid, normal_x, normal_y, normal_z, light_x, light_y, light_z,
                  view_x, view_y, view_z, light_red, light_green, light_blue,
                  input ready);
  modport sink (input valid, normal_x, normal_y, normal_z, light_x, light_y, light_z,
                view_x, view_y, view_z, light_red, light_green, light_blue,
                output ready);
endinterface

// ===== rtl/core/phs_out_if.sv =====
`timescale 1ns / 1ps
interface phs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic       lit;

  modport source (output valid, out_red, out_green, out_blue, lit, input ready);
  modport sink (input valid, out_red, out_green, out_blue, lit, output ready);
endinterface

// ===== rtl/core/phs_front.sv =====
`timescale 1ns / 1ps
module phs_front
  import phs_pkg::*;
#(
  parameter int VEC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  phs_in_if.sink      hit,
  input  fifo_stat_t  stat,
  output logic        push,
  output front_item_t item
);

  logic [VEC_BITS-1:0] raw [9];
  q14_t                q   [9];
  logic                accept;

  logic                f1_v;
  q14_t [2:0]          f1_n, f1_l, f1_v3;
  logic signed [31:0]  f1_nl [3];
  logic [2:0][7:0]     f1_lc;

  logic                f2_v;
  logic signed [33:0]  nl_sum;
  logic [33:0]         nl_rnd;

  assign raw[0] = hit.normal_x;
  assign raw[1] = hit.normal_y;
  assign raw[2] = hit.normal_z;
  assign raw[3] = hit.light_x;
  assign raw[4] = hit.light_y;
  assign raw[5] = hit.light_z;
  assign raw[6] = hit.view_x;
  assign raw[7] = hit.view_y;
  assign raw[8] = hit.view_z;

  // Bring each field to Q2.14: drop low bits or append zeros
  for (genvar i = 0; i < 9; i++) begin : g_q14
    if (VEC_BITS >= Q_W) begin : g_wide
      assign q[i] = Q_W'(raw[i] >> (VEC_BITS - Q_W));
    end else begin : g_narrow
      assign q[i] = {raw[i], {(Q_W - VEC_BITS){1'b0}}};
    end
  end

  // Accept only with room reserved in the queue for items in flight
  assign hit.ready = ((CNT_W + 1)'(stat.count) + (CNT_W + 1)'(f1_v) + (CNT_W + 1)'(f2_v))
                     < (CNT_W + 1)'(FIFO_DEPTH);
  assign accept = hit.valid & hit.ready;

  // Stage 1: register vectors and N.L partial products
  always_ff @(posedge clk) begin
    if (rst) begin
      f1_v <= 1'b0;
    end else begin
      f1_v <= accept;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      f1_n[i]  <= q[i];
      f1_l[i]  <= q[3 + i];
      f1_v3[i] <= q[6 + i];
      f1_nl[i] <= $signed(q[i]) * $signed(q[3 + i]);
    end
    f1_lc[2] <= hit.light_red;
    f1_lc[1] <= hit.light_green;
    f1_lc[0] <= hit.light_blue;
  end

  // Stage 2: sum N.L, classify facing, round to Q.14
  assign nl_sum = 34'(f1_nl[0]) + 34'(f1_nl[1]) + 34'(f1_nl[2]);
  assign nl_rnd = nl_sum + 34'(1 << (FRAC - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      f2_v <= 1'b0;
    end else begin
      f2_v <= f1_v;
    end
  end

  always_ff @(posedge clk) begin
    item.n    <= {f1_n[2], f1_n[1], f1_n[0]};
    item.l    <= {f1_l[2], f1_l[1], f1_l[0]};
    item.v    <= {f1_v3[2], f1_v3[1], f1_v3[0]};
    item.lc   <= f1_lc;
    item.lit  <= (nl_sum > 34'sd0);
    item.nl14 <= (nl_sum > 34'sd0) ? nl_rnd[FRAC +: NL14_W] : '0;
  end

  assign push = f2_v;

endmodule

// ===== rtl/core/phs_fifo.sv =====
`timescale 1ns / 1ps
module phs_fifo
  import phs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  front_item_t wr_item,
  input  logic        pop,
  output front_item_t head,
  output fifo_stat_t  stat
);

  front_item_t      slots [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  // Store incoming transaction
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_item;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + CNT_W'(push) - CNT_W'(pop);
    end
  end

  assign head       = slots[rd_ptr];
  assign stat.count = count;
  assign stat.full  = (count == CNT_W'(FIFO_DEPTH));
  assign stat.empty = (count == '0);

endmodule

// ===== rtl/core/phs_back.sv =====
`timescale 1ns / 1ps
module phs_back
  import phs_pkg::*;
#(
  parameter int EXP_BITS = 7
) (
  input  logic                clk,
  input  logic                rst,
  input  front_item_t         head,
  input  logic                empty,
  output logic                pop,
  input  logic [23:0]         diffuse,
  input  logic [23:0]         specular,
  input  logic [EXP_BITS-1:0] shininess,
  phs_out_if.source           color
);

  localparam int SQ_N  = 16;
  localparam int DV_N  = 15;
  localparam int POW_N = (EXP_BITS >= 7) ? 127 : ((1 << EXP_BITS) - 1);

  logic en;

  // Whole pipeline advances unless the result register is held
  assign en  = !color.valid || color.ready;
  assign pop = en && !empty;

  // ---------------- fixed front stages ----------------
  logic                     s1_v, s2_v, s3_v;
  q14_t [2:0]               s1_l, s1_vec, s2_vec;
  logic signed [35:0]       s1_m [3];
  logic [31:0]              s1_vsq [3];
  ctx_t                     s1_ctx, s2_ctx, s3_ctx;
  logic signed [23:0]       s2_r [3];
  logic [31:0]              s2_vv, s3_vv;
  logic signed [39:0]       s3_rvp [3];
  logic [33:0]              vv_sum;
  logic signed [41:0]       rv_sum;
  logic [35:0]              m_abs [3];
  logic [35:0]              m_rnd [3];
  logic signed [23:0]       r_mag [3];

  // ---------------- repeated stages ----------------
  logic                     sq_v   [SQ_N+1];
  logic [31:0]              sq_rem [SQ_N+1];
  logic [31:0]              sq_res [SQ_N+1];
  logic signed [41:0]       sq_rv  [SQ_N+1];
  logic                     sq_pos [SQ_N+1];
  ctx_t                     sq_ctx [SQ_N+1];

  logic                     m1_v;
  logic [31:0]              m1_vm;
  logic [VLEN_W-1:0]        m1_vlen;
  logic signed [41:0]       m1_rv;
  logic                     m1_pos;
  ctx_t                     m1_ctx;

  logic                     dv_v    [DV_N+1];
  logic [31:0]              dv_rem  [DV_N+1];
  logic [VLEN_W-1:0]        dv_vlen [DV_N+1];
  logic [COS_W-1:0]         dv_q    [DV_N+1];
  logic                     dv_zero [DV_N+1];
  logic                     dv_sat  [DV_N+1];
  ctx_t                     dv_ctx  [DV_N+1];

  logic                     pw_v   [POW_N+1];
  logic [COS_W-1:0]         pw_p   [POW_N+1];
  logic [COS_W-1:0]         pw_cos [POW_N+1];
  ctx_t                     pw_ctx [POW_N+1];

  logic                     e1_v, e2_v, e3_v;
  logic [NL14_W-1:0]        e1_s;
  ctx_t                     e1_ctx, e2_ctx, e3_ctx;
  logic [33:0]              e2_a [3];
  logic [25:0]              e2_b [3];
  logic [15:0]              e3_y [3];
  logic                     e3_sat [3];
  logic [33:0]              e1_prod;
  logic [35:0]              num [3];
  logic [35:0]              xq [3];
  logic [31:0]              recip [3];
  logic [7:0]               chan [3];

  // Valid chain of the fixed stages
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
      m1_v <= 1'b0;
      e1_v <= 1'b0;
      e2_v <= 1'b0;
      e3_v <= 1'b0;
      color.valid <= 1'b0;
    end else if (en) begin
      s1_v <= pop;
      s2_v <= s1_v;
      s3_v <= s2_v;
      m1_v <= sq_v[SQ_N];
      e1_v <= pw_v[POW_N];
      e2_v <= e1_v;
      e3_v <= e2_v;
      color.valid <= e3_v;
    end
  end

  // Reflection: round half away from zero, then subtract L
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      m_abs[i] = s1_m[i][35] ? 36'(-s1_m[i]) : 36'(s1_m[i]);
      m_rnd[i] = m_abs[i] + 36'(1 << (FRAC - 1));
      r_mag[i] = $signed({2'b00, m_rnd[i][FRAC +: 22]});
    end
  end

  assign vv_sum = 34'(s1_vsq[0]) + 34'(s1_vsq[1]) + 34'(s1_vsq[2]);
  assign rv_sum = 42'(s3_rvp[0]) + 42'(s3_rvp[1]) + 42'(s3_rvp[2]);

  // Stages 1 to 4: R, V.V, R.V and start of the square root
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s1_m[i]   <= 36'($signed({1'b0, head.nl14}) * $signed(head.n[i])) <<< 1;
        s1_vsq[i] <= 32'($signed(head.v[i]) * $signed(head.v[i]));
        s1_ctx.dl[i] <= DL_W'(diffuse[8*i +: 8] * head.lc[i]);
      end
      s1_l         <= head.l;
      s1_vec       <= head.v;
      s1_ctx.lit   <= head.lit;
      s1_ctx.nl14  <= head.nl14;

      for (int i = 0; i < 3; i++) begin
        s2_r[i] <= (s1_m[i][35] ? -r_mag[i] : r_mag[i]) - 24'($signed(s1_l[i]));
      end
      s2_vv  <= vv_sum[31:0];
      s2_vec <= s1_vec;
      s2_ctx <= s1_ctx;

      for (int i = 0; i < 3; i++) begin
        s3_rvp[i] <= 40'(s2_r[i] * $signed(s2_vec[i]));
      end
      s3_vv  <= s2_vv;
      s3_ctx <= s2_ctx;

      sq_rem[0] <= s3_vv;
      sq_res[0] <= '0;
      sq_rv[0]  <= rv_sum;
      sq_pos[0] <= (rv_sum > 42'sd0) && (s3_vv != '0);
      sq_ctx[0] <= s3_ctx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_v[0] <= 1'b0;
    end else if (en) begin
      sq_v[0] <= s3_v;
    end
  end

  // Square root of V.V, one result bit per stage
  for (genvar k = 0; k < SQ_N; k++) begin : g_sqrt
    localparam logic [31:0] SQ_BIT = 32'd1 << (30 - 2 * k);
    logic [32:0] trial;
    assign trial = {1'b0, sq_res[k]} + {1'b0, SQ_BIT};

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_v[k+1] <= 1'b0;
      end else if (en) begin
        sq_v[k+1] <= sq_v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if ({1'b0, sq_rem[k]} >= trial) begin
          sq_rem[k+1] <= sq_rem[k] - trial[31:0];
          sq_res[k+1] <= (sq_res[k] >> 1) + SQ_BIT;
        end else begin
          sq_rem[k+1] <= sq_rem[k];
          sq_res[k+1] <= sq_res[k] >> 1;
        end
        sq_rv[k+1]  <= sq_rv[k];
        sq_pos[k+1] <= sq_pos[k];
        sq_ctx[k+1] <= sq_ctx[k];
      end
    end
  end

  // Saturation bound |V| * (1.0 + 1 lsb), then classify the cosine
  always_ff @(posedge clk) begin
    if (en) begin
      m1_vm   <= 32'(sq_res[SQ_N][VLEN_W-1:0] * 15'(ONE_Q + 1));
      m1_vlen <= sq_res[SQ_N][VLEN_W-1:0];
      m1_rv   <= sq_rv[SQ_N];
      m1_pos  <= sq_pos[SQ_N];
      m1_ctx  <= sq_ctx[SQ_N];

      dv_rem[0]  <= m1_rv[31:0];
      dv_vlen[0] <= m1_vlen;
      dv_q[0]    <= '0;
      dv_zero[0] <= !m1_pos;
      dv_sat[0]  <= m1_pos && (m1_rv >= $signed({10'b0, m1_vm}));
      dv_ctx[0]  <= m1_ctx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_v[0] <= 1'b0;
    end else if (en) begin
      dv_v[0] <= m1_v;
    end
  end

  // Restoring division R.V / |V|, one quotient bit per stage
  for (genvar j = 0; j < DV_N; j++) begin : g_div
    localparam int SH = DV_N - 1 - j;
    logic [31:0] dsub;
    assign dsub = 32'(dv_vlen[j]) << SH;

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_v[j+1] <= 1'b0;
      end else if (en) begin
        dv_v[j+1] <= dv_v[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (dv_rem[j] >= dsub) begin
          dv_rem[j+1] <= dv_rem[j] - dsub;
          dv_q[j+1]   <= dv_q[j] | (COS_W'(1) << SH);
        end else begin
          dv_rem[j+1] <= dv_rem[j];
          dv_q[j+1]   <= dv_q[j];
        end
        dv_vlen[j+1] <= dv_vlen[j];
        dv_zero[j+1] <= dv_zero[j];
        dv_sat[j+1]  <= dv_sat[j];
        dv_ctx[j+1]  <= dv_ctx[j];
      end
    end
  end

  // Resolve the cosine and seed the power chain with 1.0
  always_ff @(posedge clk) begin
    if (en) begin
      priority if (dv_zero[DV_N]) begin
        pw_cos[0] <= '0;
      end else if (dv_sat[DV_N]) begin
        pw_cos[0] <= COS_W'(ONE_Q);
      end else begin
        pw_cos[0] <= dv_q[DV_N];
      end
      pw_p[0]   <= COS_W'(ONE_Q);
      pw_ctx[0] <= dv_ctx[DV_N];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pw_v[0] <= 1'b0;
    end else if (en) begin
      pw_v[0] <= dv_v[DV_N];
    end
  end

  // Power chain: one rounded product per stage while below the exponent
  for (genvar j = 0; j < POW_N; j++) begin : g_pow
    logic [29:0] prod;
    logic [29:0] rnd;
    assign prod = pw_p[j] * pw_cos[j];
    assign rnd  = prod + 30'(1 << (FRAC - 1));

    always_ff @(posedge clk) begin
      if (rst) begin
        pw_v[j+1] <= 1'b0;
      end else if (en) begin
        pw_v[j+1] <= pw_v[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        pw_p[j+1]   <= (EXP_BITS'(j) < shininess) ? rnd[FRAC +: COS_W] : pw_p[j];
        pw_cos[j+1] <= pw_cos[j];
        pw_ctx[j+1] <= pw_ctx[j];
      end
    end
  end

  // Specular scale, color products, sum and scale back to 8 bits
  assign e1_prod = 34'(pw_p[POW_N] * pw_ctx[POW_N].nl14) + 34'(1 << (FRAC - 1));

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num[i]   = 36'(e2_a[i]) + (36'(e2_b[i]) << 8) - 36'(e2_b[i]);
      xq[i]    = num[i] + 36'((255 * ONE_Q) / 2);
      recip[i] = e3_y[i] * 16'h8081;
      chan[i]  = !e3_ctx.lit ? 8'd0 : (e3_sat[i] ? 8'd255 : recip[i][30:23]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e1_s   <= e1_prod[FRAC +: NL14_W];
      e1_ctx <= pw_ctx[POW_N];

      for (int i = 0; i < 3; i++) begin
        e2_a[i] <= 34'(e1_ctx.dl[i] * e1_ctx.nl14);
        e2_b[i] <= 26'(specular[8*i +: 8] * e1_s);
      end
      e2_ctx <= e1_ctx;

      for (int i = 0; i < 3; i++) begin
        e3_y[i]   <= xq[i][FRAC +: 16];
        e3_sat[i] <= (xq[i][35:FRAC] >= 22'(256 * 255));
      end
      e3_ctx <= e2_ctx;

      color.out_red   <= chan[2];
      color.out_green <= chan[1];
      color.out_blue  <= chan[0];
      color.lit       <= e3_ctx.lit;
    end
  end

endmodule

// ===== rtl/core/phong_point_shader.sv =====
`timescale 1ns / 1ps
// Channel  | Direction | Payload
// hit      | in        | normal, light, view (Q2.14 at VEC_BITS), light color
// color    | out       | out_red, out_green, out_blue, lit
// wr_*     | in        | register write: wr_en, wr_index, wr_data
//
// One transaction per cycle, sustained, in both directions, while color is not stalled.
// The path from hit to color runs through the two front stages and the queue,
// the 16-stage square root, the 15-bit divider and one pipeline stage per
// possible power step.
// A stall on color holds the whole shading pipeline; hit keeps flowing
// into the four-entry queue until its credits run out.
// Reset (rst, synchronous) empties the pipeline and loads the register
// defaults: colors zero, shininess 10.
`include "phong_point_shader_assert.svh"
module phong_point_shader
  import phs_pkg::*;
#(
  parameter int VEC_BITS = 16,
  parameter int EXP_BITS = 7
) (
  input  logic               clk,
  input  logic               rst,
  phs_in_if.sink             hit,
  phs_out_if.source          color,
  input  logic               wr_en,
  input  logic [IDX_W-1:0]   wr_index,
  input  logic [WDATA_W-1:0] wr_data
);

  logic [23:0]         diffuse;
  logic [23:0]         specular;
  logic [EXP_BITS-1:0] shininess;

  logic                push;
  logic                pop;
  front_item_t         front_item;
  front_item_t         head;
  fifo_stat_t          fstat;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      diffuse   <= '0;
      specular  <= '0;
      shininess <= EXP_BITS'(SHIN_RESET & ((1 << EXP_BITS) - 1));
    end else if (wr_en) begin
      unique case (wr_index)
        REG_DIFFUSE:   diffuse   <= wr_data[23:0];
        REG_SPECULAR:  specular  <= wr_data[23:0];
        REG_SHININESS: shininess <= wr_data[EXP_BITS-1:0] & EXP_BITS'(127);
        default: ;
      endcase
    end
  end

  phs_front #(.VEC_BITS(VEC_BITS)) u_front (
    .clk  (clk),
    .rst  (rst),
    .hit  (hit),
    .stat (fstat),
    .push (push),
    .item (front_item)
  );

  phs_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_item (front_item),
    .pop     (pop),
    .head    (head),
    .stat    (fstat)
  );

  phs_back #(.EXP_BITS(EXP_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .empty     (fstat.empty),
    .pop       (pop),
    .diffuse   (diffuse),
    .specular  (specular),
    .shininess (shininess),
    .color     (color)
  );

  `PHS_ASSERT_NEVER(a_queue_overflow, push && fstat.full && !pop, "push into full queue")
  `PHS_ASSERT_NEVER(a_pop_empty, pop && fstat.empty, "pop from empty queue")
  `PHS_ASSERT_IMPLY(a_dark_black, color.valid && !color.lit, color.out_red == 8'd0 && color.out_green == 8'd0 && color.out_blue == 8'd0, "unlit result not black")

endmodule

// ===== dv/phong_point_shader_checker.sv =====
`timescale 1ns / 1ps
module phong_point_shader_checker
  import phs_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  phs_in_if                  hit,
  phs_out_if                 color,
  input  logic               wr_en,
  input  logic [IDX_W-1:0]   wr_index,
  input  logic [WDATA_W-1:0] wr_data,
  output int                 fail_count,
  output int                 pending
);

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       lit;
  } shade_t;

  logic [23:0] diffuse_q;
  logic [23:0] specular_q;
  logic [6:0]  shininess_q;
  shade_t      shade_q[$];

  // Integer square root, floor
  function automatic longint root_floor(longint x);
    longint res;
    longint bitv;
    res  = 0;
    bitv = longint'(1) << 62;
    while (bitv > x) bitv = bitv >>> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x   = x - (res + bitv);
        res = (res >>> 1) + bitv;
      end else begin
        res = res >>> 1;
      end
      bitv = bitv >>> 2;
    end
    return res;
  endfunction

  // Shift right by the fraction width, rounding half away from zero
  function automatic longint q_round(longint x);
    if (x < 0) return -((-x + 8192) >>> FRAC);
    return (x + 8192) >>> FRAC;
  endfunction

  // Expected color of one hit point under the current registers
  function automatic shade_t shade_hit();
    longint n[3], l[3], v[3], lc[3];
    longint nl, nl14, rv, vv, cosq, p, s, d, sp, num, c, r;
    shade_t res;
    n  = '{longint'(hit.normal_x), longint'(hit.normal_y), longint'(hit.normal_z)};
    l  = '{longint'(hit.light_x), longint'(hit.light_y), longint'(hit.light_z)};
    v  = '{longint'(hit.view_x), longint'(hit.view_y), longint'(hit.view_z)};
    lc = '{longint'(hit.light_red), longint'(hit.light_green), longint'(hit.light_blue)};
    res = '0;
    nl = 0;
    for (int i = 0; i < 3; i++) nl += n[i] * l[i];
    // back facing: black, not lit
    if (nl <= 0) return res;
    nl14 = (nl + 8192) >>> FRAC;
    rv = 0;
    vv = 0;
    for (int i = 0; i < 3; i++) begin
      r  = q_round(2 * nl14 * n[i]) - l[i];
      vv += v[i] * v[i];
      rv += r * v[i];
    end
    cosq = 0;
    if (vv != 0 && rv > 0) begin
      cosq = rv / root_floor(vv);
      if (cosq > ONE_Q) cosq = ONE_Q;
    end
    p = ONE_Q;
    for (int k = 0; k < shininess_q; k++) p = (p * cosq + 8192) >>> FRAC;
    s = (p * nl14 + 8192) >>> FRAC;
    for (int i = 0; i < 3; i++) begin
      d   = (diffuse_q >> (16 - 8 * i)) & 8'hFF;
      sp  = (specular_q >> (16 - 8 * i)) & 8'hFF;
      num = d * lc[i] * nl14 + sp * s * 255;
      c   = (num + (255 * ONE_Q) / 2) / (255 * ONE_Q);
      if (c > 255) c = 255;
      if (i == 0) res.red = c[7:0];
      else if (i == 1) res.green = c[7:0];
      else res.blue = c[7:0];
    end
    res.lit = 1'b1;
    return res;
  endfunction

  // Track registers, predict accepted hits, compare accepted colors
  always @(posedge clk) begin
    shade_t got;
    shade_t want;
    if (rst) begin
      diffuse_q   <= '0;
      specular_q  <= '0;
      shininess_q <= 7'(SHIN_RESET);
      shade_q.delete();
      fail_count  <= 0;
      pending     <= 0;
    end else begin
      if (wr_en) begin
        case (wr_index)
          REG_DIFFUSE: begin
            diffuse_q <= wr_data;
          end
          REG_SPECULAR: begin
            specular_q <= wr_data;
          end
          REG_SHININESS: begin
            shininess_q <= wr_data[6:0];
          end
          default: begin
          end
        endcase
      end
      if (hit.valid && hit.ready) shade_q.push_back(shade_hit());
      if (color.valid && color.ready) begin
        got = '{color.out_red, color.out_green, color.out_blue, color.lit};
        if (shade_q.size() == 0) begin
          if (fail_count < 10) $display("%0t: color with no hit pending: %p", $realtime, got);
          fail_count <= fail_count + 1;
        end else begin
          want = shade_q.pop_front();
          if (got !== want) begin
            if (fail_count < 10)
              $display("%0t: color mismatch: expected %p, actual %p", $realtime, want, got);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= shade_q.size();
    end
  end

endmodule

// ===== dv/phong_point_shader_test.sv =====
`timescale 1ns / 1ps
module phong_point_shader_test;
  import phs_pkg::*;

  localparam logic [IDX_W-1:0] REG_SPARE = 2'd3;

  typedef struct packed {
    logic signed [15:0] nx, ny, nz, lx, ly, lz, vx, vy, vz;
    logic [7:0]         lr, lg, lb;
  } hit_t;

  logic               clk;
  logic               rst;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_index;
  logic [WDATA_W-1:0] wr_data;
  int                 fail_count;
  int                 pending;
  bit                 steady;

  phs_in_if #(.VEC_BITS(16)) hit();
  phs_out_if color();

  phong_point_shader u_top (
    .clk      (clk),
    .rst      (rst),
    .hit      (hit),
    .color    (color),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  phong_point_shader_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .hit        (hit),
    .color      (color),
    .wr_en      (wr_en),
    .wr_index   (wr_index),
    .wr_data    (wr_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // Write one register at the next falling edge
  task automatic write_reg(logic [IDX_W-1:0] idx, logic [WDATA_W-1:0] data);
    @(negedge clk);
    wr_en    = 1'b1;
    wr_index = idx;
    wr_data  = data;
    @(negedge clk);
    wr_en    = 1'b0;
  endtask

  // Present one hit transaction and hold it until accepted
  task automatic send_hit(hit_t h);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 5);
    @(negedge clk);
    if (gap > 0) begin
      hit.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    hit.valid       = 1'b1;
    hit.normal_x    = h.nx;
    hit.normal_y    = h.ny;
    hit.normal_z    = h.nz;
    hit.light_x     = h.lx;
    hit.light_y     = h.ly;
    hit.light_z     = h.lz;
    hit.view_x      = h.vx;
    hit.view_y      = h.vy;
    hit.view_z      = h.vz;
    hit.light_red   = h.lr;
    hit.light_green = h.lg;
    hit.light_blue  = h.lb;
    @(posedge clk);
    while (!hit.ready) @(posedge clk);
  endtask

  // Small random offset around a vector component
  function automatic logic signed [15:0] jitter(int base, int span);
    return 16'(base + $signed($urandom_range(0, 2 * span)) - span);
  endfunction

  // Random hits, some well-formed: facing light, view near the mirror ray
  function automatic hit_t random_hit();
    hit_t h;
    int   kind;
    h    = hit_t'({$urandom, $urandom, $urandom, $urandom, $urandom, 8'($urandom)});
    kind = $urandom_range(0, 9);
    if (kind < 4) begin
      h.nx = jitter(0, 3000);
      h.ny = jitter(0, 3000);
      h.nz = jitter(16000, 300);
      h.lx = jitter(0, 6000);
      h.ly = jitter(0, 6000);
      h.lz = jitter(15000, 1300);
      h.vx = -h.lx + jitter(0, 800);
      h.vy = -h.ly + jitter(0, 800);
      h.vz = h.lz + jitter(0, 800);
    end else if (kind < 7) begin
      h.nx = jitter(0, 16384);
      h.ny = jitter(0, 16384);
      h.nz = jitter(0, 16384);
      h.lx = jitter(0, 16384);
      h.ly = jitter(0, 16384);
      h.lz = jitter(0, 16384);
      h.vx = jitter(0, 16384);
      h.vy = jitter(0, 16384);
      h.vz = jitter(0, 16384);
    end
    return h;
  endfunction

  // Directed corners: extremes, back facing, zero view, mirror view
  task automatic send_corners();
    hit_t h;
    h = '{16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd0, 16'sd16384,
          16'sd0, 16'sd0, 16'sd16384, 8'd255, 8'd255, 8'd255};
    send_hit(h);
    h.vz = 16'sd0;
    send_hit(h);
    h.vz = -16'sd16384;
    send_hit(h);
    h.lz = -16'sd16384;
    send_hit(h);
    h = '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
          16'sd0, 16'sd0, 16'sd0, 8'd0, 8'd0, 8'd0};
    send_hit(h);
    h = '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
          16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 8'd255, 8'd255, 8'd255};
    send_hit(h);
    h = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
          16'sh8000, 16'sh8000, 16'sh8000, 8'd128, 8'd1, 8'd127};
    send_hit(h);
    h = '{16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF,
          16'sh8000, 16'sh7FFF, 16'sh8000, 8'd0, 8'd255, 8'd0};
    send_hit(h);
    h = '{16'sd11585, 16'sd0, 16'sd11585, 16'sd0, 16'sd0, 16'sd16384,
          16'sd16384, 16'sd0, 16'sd0, 8'd200, 8'd100, 8'd50};
    send_hit(h);
    h = '{16'sd0, 16'sd16384, 16'sd0, 16'sd1, 16'sd1, 16'sd0,
          16'sd0, 16'sd1, 16'sd0, 8'd255, 8'd0, 8'd255};
    send_hit(h);
  endtask

  // Drain outstanding colors, then let the pipeline settle
  task automatic drain();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (250) @(posedge clk);
  endtask

  // Color side: random stalls, with stall-free stretches
  initial begin
    int stall;
    color.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        color.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      color.ready = 1'b1;
      @(posedge clk);
      while (!color.valid) @(posedge clk);
      @(negedge clk);
    end
  end

  // Stimulus and verdict
  initial begin
    logic [23:0] diff_set[5];
    logic [23:0] spec_set[5];
    logic [6:0]  shin_set[5];
    rst       = 1'b1;
    wr_en     = 1'b0;
    wr_index  = REG_DIFFUSE;
    wr_data   = '0;
    steady    = 1'b0;
    hit.valid = 1'b0;
    {hit.normal_x, hit.normal_y, hit.normal_z} = '0;
    {hit.light_x, hit.light_y, hit.light_z}    = '0;
    {hit.view_x, hit.view_y, hit.view_z}       = '0;
    {hit.light_red, hit.light_green, hit.light_blue} = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset registers first, then extremes and random settings
    diff_set = '{24'h000000, 24'hFFFFFF, 24'(($urandom)), 24'h000000, 24'h80FF01};
    spec_set = '{24'h000000, 24'hFFFFFF, 24'(($urandom)), 24'hFFFFFF, 24'h7F0080};
    shin_set = '{7'd10, 7'd0, 7'd127, 7'd1, 7'($urandom_range(2, 40))};
    for (int ph = 0; ph < 5; ph++) begin
      if (ph > 0) begin
        write_reg(REG_DIFFUSE, diff_set[ph]);
        write_reg(REG_SPECULAR, spec_set[ph]);
        write_reg(REG_SHININESS, {17'($urandom), shin_set[ph]});
        write_reg(REG_SPARE, 24'($urandom));
      end
      send_corners();
      for (int i = 0; i < 80; i++) begin
        if (i % 20 == 0) steady = ($urandom_range(0, 3) == 0);
        send_hit(random_hit());
      end
      steady = 1'b0;
      @(negedge clk);
      hit.valid = 1'b0;
      drain();
    end

    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
